>>> src/omre_pkg.sv
// shared types, constants and codes for the ordered multiset rank engine
`default_nettype none

package omre_pkg;

    // store geometry
    localparam int CAPACITY    = 1024;
    localparam int VALUE_W     = 32;
    localparam int IDX_W       = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W       = $clog2(CAPACITY + 1);
    localparam int GROUP_SIZE  = (CAPACITY < 32) ? CAPACITY : 32;
    localparam int NUM_GROUPS  = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int PAD_CELLS   = NUM_GROUPS * GROUP_SIZE;
    localparam int GRP_CNT_W   = $clog2(GROUP_SIZE + 1);

    // command codes
    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_DELETE = 3'd1;
    localparam logic [2:0] CMD_RANK   = 3'd2;
    localparam logic [2:0] CMD_AT     = 3'd3;
    localparam logic [2:0] CMD_PRED   = 3'd4;
    localparam logic [2:0] CMD_SUCC   = 3'd5;

    typedef logic signed [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] operand;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] answer;
        logic               found;
    } t_out_item;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_GRP,
        ST_TOP
    } t_state;

    // broadcast to every cell
    typedef struct packed {
        logic [2:0]       cmd;
        logic             cmp_en;
        logic             ins_en;
        logic             del_en;
        t_value           x;
        logic [IDX_W-1:0] rank_idx;
        logic             rank_ok;
        logic [CNT_W-1:0] count;
    } t_cell_ctrl;

    // registered summary of one group of cells
    typedef struct packed {
        logic [GRP_CNT_W-1:0] cnt;
        logic                 hit;
        logic                 sel;
        t_value               value;
    } t_grp_sum;

endpackage

`default_nettype wire

>>> src/omre_cell.sv
// one storage cell of the sorted chain: compare flags and neighbor shifting
`default_nettype none

module omre_cell (
    input  wire logic                      i_clk,
    input  wire logic [omre_pkg::IDX_W-1:0] i_index,
    input  wire omre_pkg::t_cell_ctrl      i_ctrl,
    input  wire logic                      i_left_le,
    input  wire logic                      i_left_lt,
    input  wire omre_pkg::t_value          i_left_value,
    input  wire logic                      i_right_lt,
    input  wire omre_pkg::t_value          i_right_value,
    output omre_pkg::t_value               o_value,
    output logic                           o_le,
    output logic                           o_lt,
    output logic                           o_sel,
    output logic                           o_hit
);

    omre_pkg::t_value r_value;
    logic             r_valid;
    logic             r_lt;
    logic             r_le;
    logic             r_eq;
    logic             r_rank;
    logic             valid;

    assign valid = omre_pkg::CNT_W'(i_index) < i_ctrl.count;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmp_en) begin
            r_valid <= valid;
            r_lt    <= valid && (r_value < i_ctrl.x);
            r_le    <= valid && (r_value <= i_ctrl.x);
            r_eq    <= valid && (r_value == i_ctrl.x);
            r_rank  <= i_ctrl.rank_ok && (i_index == i_ctrl.rank_idx);
        end
        // insert opens a gap at the first cell above x
        if (i_ctrl.ins_en && !r_le) begin
            r_value <= i_left_le ? i_ctrl.x : i_left_value;
        end else if (i_ctrl.del_en && !r_lt) begin
            r_value <= i_right_value;
        end
    end

    always_comb begin
        case (i_ctrl.cmd)
            omre_pkg::CMD_PRED: o_sel = r_lt && !i_right_lt;
            omre_pkg::CMD_SUCC: o_sel = r_valid && !r_le && i_left_le;
            omre_pkg::CMD_AT:   o_sel = r_rank;
            default:            o_sel = 1'b0;
        endcase
    end

    assign o_hit   = r_eq && i_left_lt;
    assign o_value = r_value;
    assign o_le    = r_le;
    assign o_lt    = r_lt;

endmodule

`default_nettype wire

>>> src/omre_group.sv
// registered reduction over one group of cells: count, hit and selected value
`default_nettype none

module omre_group (
    input  wire logic             i_clk,
    input  wire logic             i_lt    [omre_pkg::GROUP_SIZE],
    input  wire logic             i_hit   [omre_pkg::GROUP_SIZE],
    input  wire logic             i_sel   [omre_pkg::GROUP_SIZE],
    input  wire omre_pkg::t_value i_value [omre_pkg::GROUP_SIZE],
    output omre_pkg::t_grp_sum    o_sum
);

    omre_pkg::t_grp_sum r_sum;
    omre_pkg::t_grp_sum n_sum;

    always_comb begin
        n_sum = '0;
        for (int j = 0; j < omre_pkg::GROUP_SIZE; j++) begin
            n_sum.cnt = n_sum.cnt + omre_pkg::GRP_CNT_W'(i_lt[j]);
            n_sum.hit = n_sum.hit | i_hit[j];
            n_sum.sel = n_sum.sel | i_sel[j];
            if (i_sel[j]) begin
                n_sum.value = n_sum.value | i_value[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= n_sum;
    end

    assign o_sum = r_sum;

endmodule

`default_nettype wire

>>> src/ordered_multiset_rank_engine.sv
// top level: bounded sorted multiset kept in a chain of cells with rank queries
//
//   channel | direction | payload                 | handshake
//   in      | input     | t_in_item  (cmd, operand) | i_in_valid / o_in_stall
//   out     | output    | t_out_item (answer, found)| o_out_valid / i_out_stall
//
// every transaction passes through four steps: accept, cell compare, group reduction,
// final reduction where the result is loaded or the chain shifts
// the final reduction step of a query waits while an earlier result is still stalled
// the input stalls from accept until the final step completes
// reset clears the element count and the control state; cell contents are
// left as they are and never read before being written, so no clearing pass
`default_nettype none

module ordered_multiset_rank_engine (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire omre_pkg::t_in_item i_in_data,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output omre_pkg::t_out_item     o_out_data
);

    omre_pkg::t_state r_state;
    omre_pkg::t_state n_state;

    // transaction held for the whole pass
    logic [2:0]                r_cmd;
    omre_pkg::t_value          r_x;
    logic [omre_pkg::IDX_W-1:0] r_rank_idx;
    logic                      r_rank_ok;
    logic [omre_pkg::CNT_W-1:0] r_count;
    logic [omre_pkg::CNT_W-1:0] n_count;

    logic                r_out_valid;
    omre_pkg::t_out_item r_out_data;
    logic                load_out;

    logic                accept;
    logic                is_query;
    logic                not_full;
    logic                del_ok;
    logic                any_sel;
    logic [omre_pkg::CNT_W-1:0] tot_cnt;
    omre_pkg::t_value    sel_value;
    omre_pkg::t_out_item result;
    omre_pkg::t_cell_ctrl ctrl;

    logic [31:0] op_u;

    // cell outputs, padded up to whole groups
    logic             c_lt    [omre_pkg::PAD_CELLS];
    logic             c_le    [omre_pkg::PAD_CELLS];
    logic             c_hit   [omre_pkg::PAD_CELLS];
    logic             c_sel   [omre_pkg::PAD_CELLS];
    omre_pkg::t_value c_value [omre_pkg::PAD_CELLS];

    omre_pkg::t_grp_sum g_sum [omre_pkg::NUM_GROUPS];

    assign accept   = i_in_valid && !o_in_stall;
    assign op_u     = i_in_data.operand;
    assign is_query = (r_cmd == omre_pkg::CMD_RANK) || (r_cmd == omre_pkg::CMD_AT) ||
                      (r_cmd == omre_pkg::CMD_PRED) || (r_cmd == omre_pkg::CMD_SUCC);
    assign not_full = r_count < omre_pkg::CNT_W'(omre_pkg::CAPACITY);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= omre_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and step controls
    always_comb begin
        n_state     = r_state;
        o_in_stall  = 1'b1;
        load_out    = 1'b0;
        ctrl        = '0;
        ctrl.cmd      = r_cmd;
        ctrl.x        = r_x;
        ctrl.rank_idx = r_rank_idx;
        ctrl.rank_ok  = r_rank_ok;
        ctrl.count    = r_count;
        case (r_state)
            omre_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_state = omre_pkg::ST_CMP;
                end
            end
            omre_pkg::ST_CMP: begin
                ctrl.cmp_en = 1'b1;
                n_state     = omre_pkg::ST_GRP;
            end
            omre_pkg::ST_GRP: begin
                n_state = omre_pkg::ST_TOP;
            end
            omre_pkg::ST_TOP: begin
                // a query waits here while the previous result is stalled
                if (!(is_query && r_out_valid && i_out_stall)) begin
                    load_out    = is_query;
                    ctrl.ins_en = (r_cmd == omre_pkg::CMD_INSERT) && not_full;
                    ctrl.del_en = (r_cmd == omre_pkg::CMD_DELETE) && del_ok;
                    n_state     = omre_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = omre_pkg::ST_IDLE;
            end
        endcase
    end

    // capture the transaction; precompute the rank range check
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd      <= i_in_data.cmd;
            r_x        <= omre_pkg::t_value'(i_in_data.operand);
            r_rank_idx <= omre_pkg::IDX_W'(op_u - 32'd1);
            r_rank_ok  <= !op_u[31] && (op_u != 32'd0) && (op_u <= 32'(r_count));
        end
    end

    // element count
    always_comb begin
        n_count = r_count;
        if (ctrl.ins_en) begin
            n_count = r_count + omre_pkg::CNT_W'(1);
        end else if (ctrl.del_en) begin
            n_count = r_count - omre_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // chain of cells, each talking to its left and right neighbor
    for (genvar c = 0; c < omre_pkg::PAD_CELLS; c++) begin : g_cell
        if (c < omre_pkg::CAPACITY) begin : g_real
            logic             left_le;
            logic             left_lt;
            omre_pkg::t_value left_value;
            logic             right_lt;
            omre_pkg::t_value right_value;

            if (c == 0) begin : g_first
                // the chain's left edge acts as an entry below everything
                assign left_le    = 1'b1;
                assign left_lt    = 1'b1;
                assign left_value = r_x;
            end else begin : g_inner_left
                assign left_le    = c_le[c-1];
                assign left_lt    = c_lt[c-1];
                assign left_value = c_value[c-1];
            end

            if (c == omre_pkg::CAPACITY - 1) begin : g_last
                assign right_lt    = 1'b0;
                assign right_value = c_value[c];
            end else begin : g_inner_right
                assign right_lt    = c_lt[c+1];
                assign right_value = c_value[c+1];
            end

            omre_cell u_cell (
                .i_clk         (i_clk),
                .i_index       (omre_pkg::IDX_W'(c)),
                .i_ctrl        (ctrl),
                .i_left_le     (left_le),
                .i_left_lt     (left_lt),
                .i_left_value  (left_value),
                .i_right_lt    (right_lt),
                .i_right_value (right_value),
                .o_value       (c_value[c]),
                .o_le          (c_le[c]),
                .o_lt          (c_lt[c]),
                .o_sel         (c_sel[c]),
                .o_hit         (c_hit[c])
            );
        end else begin : g_pad
            assign c_value[c] = '0;
            assign c_le[c]    = 1'b0;
            assign c_lt[c]    = 1'b0;
            assign c_sel[c]   = 1'b0;
            assign c_hit[c]   = 1'b0;
        end
    end

    // first reduction level, one registered summary per group
    for (genvar g = 0; g < omre_pkg::NUM_GROUPS; g++) begin : g_group
        omre_group u_group (
            .i_clk   (i_clk),
            .i_lt    (c_lt[g*omre_pkg::GROUP_SIZE +: omre_pkg::GROUP_SIZE]),
            .i_hit   (c_hit[g*omre_pkg::GROUP_SIZE +: omre_pkg::GROUP_SIZE]),
            .i_sel   (c_sel[g*omre_pkg::GROUP_SIZE +: omre_pkg::GROUP_SIZE]),
            .i_value (c_value[g*omre_pkg::GROUP_SIZE +: omre_pkg::GROUP_SIZE]),
            .o_sum   (g_sum[g])
        );
    end

    // final reduction across the groups
    always_comb begin
        tot_cnt   = '0;
        del_ok    = 1'b0;
        any_sel   = 1'b0;
        sel_value = '0;
        for (int g = 0; g < omre_pkg::NUM_GROUPS; g++) begin
            tot_cnt   = tot_cnt + omre_pkg::CNT_W'(g_sum[g].cnt);
            del_ok    = del_ok | g_sum[g].hit;
            any_sel   = any_sel | g_sum[g].sel;
            sel_value = sel_value | g_sum[g].value;
        end
    end

    // lt flags form a prefix, so their count is the position of x
    always_comb begin
        result = '0;
        if (r_cmd == omre_pkg::CMD_RANK) begin
            result.answer = $signed(32'(tot_cnt) + 32'd1);
            result.found  = 1'b1;
        end else if (any_sel) begin
            result.answer = 32'(sel_value);
            result.found  = 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_data <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

>>> src/omre_checker.sv
// port-level checks for the ordered multiset rank engine, bound to the top level
`default_nettype none

module omre_checker (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_in_valid,
    input wire logic                o_in_stall,
    input wire logic                o_out_valid,
    input wire logic                i_out_stall,
    input wire omre_pkg::t_out_item o_out_data
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_data))
        else $error("result changed while stalled");

    // after an accept the input stays stalled through the compare, group and final steps
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall ##1 o_in_stall ##1 o_in_stall)
        else $error("transaction accepted too early");

    // a query without an answer reports zero
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.found || (o_out_data.answer == 32'sd0))
        else $error("missing answer is not zero");

endmodule

bind ordered_multiset_rank_engine omre_checker u_omre_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the ordered multiset rank engine
`default_nettype none

module testbench;
    import omre_pkg::*;

    // codes the block must ignore without a result
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;

    // input idling and output stalls are switched off inside this cycle window
    localparam int CALM_FROM = 1500;
    localparam int CALM_TO   = 3500;

    typedef struct {
        t_in_item item;
        bit       hold;     // wait until no result is outstanding
    } t_stim;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_item o_out_data;

    ordered_multiset_rank_engine dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_data (o_out_data)
    );

    t_stim             stim_q[$];       // transactions not yet presented
    t_out_item         answer_q[$];     // query answers still owed by the block
    logic signed [31:0] shadow_set[$];  // predicted store contents, ascending
    logic signed [31:0] gen_pool[$];    // values believed stored, for stimulus only

    int  error_count = 0;
    int  cycle_count = 0;
    bit  in_taken    = 1'b0;
    bit  calm;

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // number of stored values below x, or at most x when or_equal is set
    function automatic int unsigned values_below(logic signed [31:0] x, bit or_equal);
        int unsigned n;
        n = 0;
        foreach (shadow_set[i]) begin
            if (shadow_set[i] < x || (or_equal && shadow_set[i] == x))
                n++;
        end
        return n;
    endfunction

    // apply one transaction to the shadow store; returns 1 when a query answer is due
    function automatic bit multiset_query(t_in_item it, output t_out_item ans);
        int unsigned pos;
        logic signed [31:0] x;
        x   = it.operand;
        ans = '0;
        case (it.cmd)
            CMD_INSERT: begin
                // a full store drops the insert
                if (shadow_set.size() < CAPACITY) begin
                    pos = values_below(x, 1'b1);
                    shadow_set.insert(pos, x);
                end
                return 1'b0;
            end
            CMD_DELETE: begin
                // only one copy goes; an absent value changes nothing
                pos = values_below(x, 1'b0);
                if (pos < shadow_set.size() && shadow_set[pos] == x)
                    shadow_set.delete(pos);
                return 1'b0;
            end
            CMD_RANK: begin
                ans.answer = values_below(x, 1'b0) + 1;
                ans.found  = 1'b1;
                return 1'b1;
            end
            CMD_AT: begin
                // rank is the full signed operand, 1 = smallest
                if (x >= 1 && x <= shadow_set.size()) begin
                    ans.answer = shadow_set[x - 1];
                    ans.found  = 1'b1;
                end
                return 1'b1;
            end
            CMD_PRED: begin
                pos = values_below(x, 1'b0);
                if (pos > 0) begin
                    ans.answer = shadow_set[pos - 1];
                    ans.found  = 1'b1;
                end
                return 1'b1;
            end
            CMD_SUCC: begin
                pos = values_below(x, 1'b1);
                if (pos < shadow_set.size()) begin
                    ans.answer = shadow_set[pos];
                    ans.found  = 1'b1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        error_count++;
    endtask

    // ------------------------------------------------------------------
    // stimulus generation
    // ------------------------------------------------------------------

    task automatic add_item(logic [2:0] cmd, logic signed [31:0] operand, bit hold);
        t_stim s;
        s.item.cmd     = cmd;
        s.item.operand = operand;
        s.hold         = hold;
        stim_q = {stim_q, s};
    endtask

    // mix of small values (many duplicates), range extremes, stored values and
    // full-width random values
    function automatic logic signed [31:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return $urandom_range(0, 12) - 6;
        if (r < 40) begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MIN + 1;
                2: return VAL_MAX;
                default: return VAL_MAX - 1;
            endcase
        end
        if (r < 60 && gen_pool.size() != 0)
            return gen_pool[$urandom_range(0, gen_pool.size() - 1)];
        return $urandom;
    endfunction

    // ranks mostly in range, with zero, negatives and the top of the range
    function automatic logic signed [31:0] pick_rank();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 14)
            return $urandom | 32'h8000_0000;
        if (r < 18)
            return VAL_MAX;
        return $urandom_range(1, gen_pool.size() + 2);
    endfunction

    task automatic add_random(int unsigned ins_pct, int unsigned del_pct);
        int unsigned r;
        int unsigned k;
        logic signed [31:0] v;
        r = $urandom_range(0, 99);
        if (r < ins_pct) begin
            v = pick_value();
            add_item(CMD_INSERT, v, 1'b0);
            gen_pool = {gen_pool, v};
        end else if (r < ins_pct + del_pct) begin
            // mostly delete something stored, sometimes an arbitrary value
            if (gen_pool.size() != 0 && $urandom_range(0, 4) != 0) begin
                k = $urandom_range(0, gen_pool.size() - 1);
                v = gen_pool[k];
                gen_pool.delete(k);
            end else begin
                v = pick_value();
            end
            add_item(CMD_DELETE, v, 1'b0);
        end else if (r < 97) begin
            case ($urandom_range(0, 3))
                0: add_item(CMD_RANK, pick_value(), 1'b0);
                1: add_item(CMD_AT, pick_rank(), 1'b0);
                2: add_item(CMD_PRED, pick_value(), 1'b0);
                default: add_item(CMD_SUCC, pick_value(), 1'b0);
            endcase
        end else begin
            add_item($urandom_range(0, 1) ? CMD_RSVD_7 : CMD_RSVD_6, $urandom, 1'b0);
        end
    endtask

    // ------------------------------------------------------------------
    // driver: inputs change on the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        calm = (cycle_count >= CALM_FROM && cycle_count < CALM_TO);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_taken) begin
            // a held transaction waits until every owed answer has come back
            if (stim_q.size() != 0 && !(stim_q[0].hold && answer_q.size() != 0) &&
                (calm || $urandom_range(0, 99) >= 10)) begin
                i_in_valid <= 1'b1;
                i_in_data  <= stim_q[0].item;
                void'(stim_q.pop_front());
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= !calm && ($urandom_range(0, 99) < 10);
    end

    // ------------------------------------------------------------------
    // monitor: sampled on the rising edge, before the block updates
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item fresh;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
        in_taken = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    report_mismatch("unexpected result, answer", o_out_data.answer, 0);
                end else begin
                    want = answer_q.pop_front();
                    if (o_out_data.answer !== want.answer)
                        report_mismatch("answer", o_out_data.answer, want.answer);
                    if (o_out_data.found !== want.found)
                        report_mismatch("found", 32'(o_out_data.found), 32'(want.found));
                end
            end
            if (i_in_valid && !o_in_stall) begin
                in_taken = 1'b1;
                if (multiset_query(i_in_data, fresh))
                    answer_q = {answer_q, fresh};
            end
        end
    end

    // ------------------------------------------------------------------
    // sequence: reset, stimulus, drain, verdict
    // ------------------------------------------------------------------
    initial begin
        int i;

        // directed: empty store first
        add_item(CMD_RANK,   5,       1'b0);
        add_item(CMD_AT,     1,       1'b0);
        add_item(CMD_PRED,   0,       1'b0);
        add_item(CMD_SUCC,   0,       1'b0);
        add_item(CMD_DELETE, 3,       1'b0);  // absent value
        add_item(CMD_INSERT, VAL_MAX, 1'b0);
        add_item(CMD_INSERT, VAL_MIN, 1'b0);
        add_item(CMD_INSERT, 0,       1'b0);
        add_item(CMD_INSERT, 0,       1'b0);  // duplicate
        add_item(CMD_INSERT, -1,      1'b0);
        add_item(CMD_RANK,   VAL_MAX, 1'b0);
        add_item(CMD_RANK,   VAL_MIN, 1'b0);
        add_item(CMD_RANK,   1,       1'b0);
        add_item(CMD_AT,     0,       1'b0);  // rank below range
        add_item(CMD_AT,     VAL_MIN, 1'b0);
        add_item(CMD_AT,     VAL_MAX, 1'b0);
        add_item(CMD_AT,     5,       1'b0);
        add_item(CMD_AT,     6,       1'b0);  // just above count
        add_item(CMD_PRED,   VAL_MIN, 1'b0);  // no predecessor
        add_item(CMD_SUCC,   VAL_MAX, 1'b0);  // no successor, top of range
        add_item(CMD_PRED,   VAL_MAX, 1'b0);
        add_item(CMD_SUCC,   VAL_MIN, 1'b0);
        add_item(CMD_DELETE, 0,       1'b0);  // one copy only
        add_item(CMD_DELETE, 7,       1'b0);
        add_item(CMD_RSVD_6, 32'hFFFF_FFFF, 1'b0);
        add_item(CMD_RSVD_7, 0,       1'b0);
        add_item(CMD_SUCC,   -1,      1'b0);
        gen_pool = '{VAL_MAX, VAL_MIN, 0, -1};

        // mixed traffic on a lightly filled store
        for (i = 0; i < 60; i++)
            add_random(40, 25);

        // fill past capacity so the last inserts are dropped, with queries mixed in
        for (i = 0; i < CAPACITY + 8; i++) begin
            add_random(100, 0);
            if ($urandom_range(0, 99) < 8)
                add_random(0, 0);
        end
        add_item(CMD_AT,   CAPACITY,     1'b1);
        add_item(CMD_AT,   CAPACITY + 1, 1'b0);
        add_item(CMD_RANK, VAL_MAX,      1'b0);
        add_item(CMD_SUCC, VAL_MIN,      1'b0);
        add_item(CMD_PRED, VAL_MAX,      1'b0);

        // delete-heavy phase, entered with the block drained
        add_item(CMD_RANK, 0, 1'b1);
        for (i = 0; i < 100; i++)
            add_random(10, 55);

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (stim_q.size() != 0 || i_in_valid || answer_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
